>>> rtl/csg_pkg.sv
// ============================================================================
// csg_pkg - shared types and constants of the clipped rectangle span generator
// Holds the clip window layout, the box record and the register map.
// ============================================================================
package csg_pkg;

    localparam int CoordW   = 16;
    localparam int ExtW     = CoordW + 1;
    localparam int PaintW   = 24;
    localparam int NumBoxes = 4;
    localparam int AddrW    = 4;
    localparam int DataW    = 32;

    localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
    localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

    localparam logic signed [CoordW-1:0] ResetClipLeft   = 16'sd0;
    localparam logic signed [CoordW-1:0] ResetClipTop    = 16'sd0;
    localparam logic signed [CoordW-1:0] ResetClipRight  = 16'sd800;
    localparam logic signed [CoordW-1:0] ResetClipBottom = 16'sd480;

    typedef struct packed {
        logic signed [CoordW-1:0] left;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] right;
        logic signed [CoordW-1:0] bottom;
    } clip_t;

    typedef struct packed {
        logic signed [CoordW-1:0] x_lo;
        logic signed [CoordW-1:0] x_hi;
        logic signed [CoordW-1:0] y_lo;
        logic signed [CoordW-1:0] y_hi;
    } box_t;

    typedef struct packed {
        logic [NumBoxes-1:0]               mask;
        box_t [NumBoxes-1:0]               boxes;
        logic [PaintW-1:0]                 paint;
    } box_set_t;

endpackage

>>> rtl/csg_cfg_regs.sv
// ============================================================================
// csg_cfg_regs - clip window registers
// APB-style register file holding the four clip window bounds.
// ============================================================================
module csg_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csg_pkg::AddrW-1:0]      paddr,
    input  logic [csg_pkg::DataW-1:0]      pwdata,
    output logic [csg_pkg::DataW-1:0]      prdata,
    output logic                           pready,
    output csg_pkg::clip_t                 clip
);

    csg_pkg::clip_t clip_reg;
    csg_pkg::clip_t clip_next;
    logic           wr_en;
    logic [1:0]     reg_idx;
    logic signed [csg_pkg::CoordW-1:0] wdata;
    logic signed [csg_pkg::CoordW-1:0] rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[csg_pkg::AddrW-1:2];
    assign wdata   = $signed(pwdata[csg_pkg::CoordW-1:0]);

    always_comb
    begin
        clip_next = clip_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                csg_pkg::REG_CLIP_LEFT:   clip_next.left   = wdata;
                csg_pkg::REG_CLIP_TOP:    clip_next.top    = wdata;
                csg_pkg::REG_CLIP_RIGHT:  clip_next.right  = wdata;
                csg_pkg::REG_CLIP_BOTTOM: clip_next.bottom = wdata;
                default:                  clip_next        = clip_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            csg_pkg::REG_CLIP_LEFT:   rdata = clip_reg.left;
            csg_pkg::REG_CLIP_TOP:    rdata = clip_reg.top;
            csg_pkg::REG_CLIP_RIGHT:  rdata = clip_reg.right;
            csg_pkg::REG_CLIP_BOTTOM: rdata = clip_reg.bottom;
            default:                  rdata = '0;
        endcase
    end

    assign prdata = {{(csg_pkg::DataW-csg_pkg::CoordW){rdata[csg_pkg::CoordW-1]}}, rdata};
    assign clip   = clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= csg_pkg::ResetClipLeft;
            clip_reg.top    <= csg_pkg::ResetClipTop;
            clip_reg.right  <= csg_pkg::ResetClipRight;
            clip_reg.bottom <= csg_pkg::ResetClipBottom;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

endmodule

>>> rtl/csg_clip.sv
// ============================================================================
// csg_clip - request register and clipping logic
// Registers one request and works out all candidate boxes with their mask.
// ============================================================================
module csg_clip (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [csg_pkg::CoordW-1:0]  start_x,
    input  logic signed [csg_pkg::CoordW-1:0]  start_y,
    input  logic signed [csg_pkg::CoordW-1:0]  len_x,
    input  logic signed [csg_pkg::CoordW-1:0]  len_y,
    input  logic                               solid,
    input  logic [csg_pkg::PaintW-1:0]         paint,
    input  csg_pkg::clip_t                     clip,
    input  logic                               take_ok,
    output logic                               set_valid,
    output csg_pkg::box_set_t                  set_out
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [csg_pkg::CoordW-1:0] sx_reg;
    logic signed [csg_pkg::CoordW-1:0] sy_reg;
    logic signed [csg_pkg::CoordW-1:0] lx_reg;
    logic signed [csg_pkg::CoordW-1:0] ly_reg;
    logic                              solid_reg;
    logic [csg_pkg::PaintW-1:0]        paint_reg;
    logic                              accept;
    logic                              load;

    logic signed [csg_pkg::ExtW-1:0] xs, ys, xe, ye;
    logic signed [csg_pkg::ExtW-1:0] cl, ct, cr, cb;
    logic signed [csg_pkg::ExtW-1:0] x0, x1, y0, y1;
    logic signed [csg_pkg::ExtW-1:0] xs_p1, ys_p1, xe_m1, ye_m1;
    logic                            rejected;
    logic                            x_ne, y_ne;
    logic [csg_pkg::NumBoxes-1:0]    mask;

    assign load       = valid_reg && take_ok;
    assign busy       = valid_reg && !take_ok;
    assign accept     = start && !busy;
    assign valid_next = accept || (valid_reg && !load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg    <= start_x;
            sy_reg    <= start_y;
            lx_reg    <= len_x;
            ly_reg    <= len_y;
            solid_reg <= solid;
            paint_reg <= paint;
        end
    end

    always_comb
    begin
        xs = csg_pkg::ExtW'(sx_reg);
        ys = csg_pkg::ExtW'(sy_reg);
        xe = xs + csg_pkg::ExtW'(lx_reg);
        ye = ys + csg_pkg::ExtW'(ly_reg);
        cl = csg_pkg::ExtW'(clip.left);
        ct = csg_pkg::ExtW'(clip.top);
        cr = csg_pkg::ExtW'(clip.right);
        cb = csg_pkg::ExtW'(clip.bottom);
        xs_p1 = xs + csg_pkg::ExtW'(1);
        ys_p1 = ys + csg_pkg::ExtW'(1);
        xe_m1 = xe - csg_pkg::ExtW'(1);
        ye_m1 = ye - csg_pkg::ExtW'(1);
        rejected = (xs >= cr) || (ys >= cb) || (xe < cl) || (ye < ct);
        x0 = (xs > cl) ? xs : cl;
        x1 = (xe < cr) ? xe : cr;
        y0 = (ys > ct) ? ys : ct;
        y1 = (ye < cb) ? ye : cb;
        x_ne = x0 < x1;
        y_ne = y0 < y1;

        set_out.paint = paint_reg;
        set_out.boxes = '0;
        mask          = '0;
        if (solid_reg)
        begin
            mask[0] = x_ne && y_ne;
            set_out.boxes[0].x_lo = $signed(x0[csg_pkg::CoordW-1:0]);
            set_out.boxes[0].x_hi = $signed(x1[csg_pkg::CoordW-1:0]);
            set_out.boxes[0].y_lo = $signed(y0[csg_pkg::CoordW-1:0]);
            set_out.boxes[0].y_hi = $signed(y1[csg_pkg::CoordW-1:0]);
        end
        else
        begin
            mask[0] = (ys >= ct) && x_ne;
            mask[1] = (ye <= cb) && (ye > ct) && x_ne;
            mask[2] = (xs >= cl) && y_ne;
            mask[3] = (xe <= cr) && (xe > cl) && y_ne;
            set_out.boxes[0].x_lo = $signed(x0[csg_pkg::CoordW-1:0]);
            set_out.boxes[0].x_hi = $signed(x1[csg_pkg::CoordW-1:0]);
            set_out.boxes[0].y_lo = sy_reg;
            set_out.boxes[0].y_hi = $signed(ys_p1[csg_pkg::CoordW-1:0]);
            set_out.boxes[1].x_lo = $signed(x0[csg_pkg::CoordW-1:0]);
            set_out.boxes[1].x_hi = $signed(x1[csg_pkg::CoordW-1:0]);
            set_out.boxes[1].y_lo = $signed(ye_m1[csg_pkg::CoordW-1:0]);
            set_out.boxes[1].y_hi = $signed(ye[csg_pkg::CoordW-1:0]);
            set_out.boxes[2].x_lo = sx_reg;
            set_out.boxes[2].x_hi = $signed(xs_p1[csg_pkg::CoordW-1:0]);
            set_out.boxes[2].y_lo = $signed(y0[csg_pkg::CoordW-1:0]);
            set_out.boxes[2].y_hi = $signed(y1[csg_pkg::CoordW-1:0]);
            set_out.boxes[3].x_lo = $signed(xe_m1[csg_pkg::CoordW-1:0]);
            set_out.boxes[3].x_hi = $signed(xe[csg_pkg::CoordW-1:0]);
            set_out.boxes[3].y_lo = $signed(y0[csg_pkg::CoordW-1:0]);
            set_out.boxes[3].y_hi = $signed(y1[csg_pkg::CoordW-1:0]);
        end
        set_out.mask = rejected ? '0 : mask;
    end

    assign set_valid = load;

endmodule

>>> rtl/csg_emit.sv
// ============================================================================
// csg_emit - box buffer and result register
// Holds the boxes of one request and sends them out one per cycle.
// ============================================================================
module csg_emit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               set_valid,
    input  csg_pkg::box_set_t                  set_in,
    output logic                               take_ok,
    output logic                               box_valid,
    output logic signed [csg_pkg::CoordW-1:0]  box_x_lo,
    output logic signed [csg_pkg::CoordW-1:0]  box_x_hi,
    output logic signed [csg_pkg::CoordW-1:0]  box_y_lo,
    output logic signed [csg_pkg::CoordW-1:0]  box_y_hi,
    output logic [csg_pkg::PaintW-1:0]         box_paint,
    output logic                               final_box
);

    logic [csg_pkg::NumBoxes-1:0] mask_reg;
    logic [csg_pkg::NumBoxes-1:0] mask_next;
    logic [csg_pkg::NumBoxes-1:0] pick;
    logic [csg_pkg::NumBoxes-1:0] rest;
    csg_pkg::box_t [csg_pkg::NumBoxes-1:0] boxes_reg;
    logic [csg_pkg::PaintW-1:0]   paint_reg;
    csg_pkg::box_t                sel_box;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         final_reg;
    logic                         final_next;
    csg_pkg::box_t                out_box_reg;
    logic [csg_pkg::PaintW-1:0]   out_paint_reg;

    assign take_ok = ($countones(mask_reg) <= 1);
    assign pick    = mask_reg & (~mask_reg + 1'b1);
    assign rest    = mask_reg & ~pick;

    always_comb
    begin
        sel_box = boxes_reg[0];
        for (int i = csg_pkg::NumBoxes - 1; i >= 0; i--)
        begin
            if (pick[i])
            begin
                sel_box = boxes_reg[i];
            end
        end
        valid_next = |mask_reg;
        final_next = (|mask_reg) && (rest == '0);
        mask_next  = set_valid ? set_in.mask : rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_valid)
        begin
            boxes_reg <= set_in.boxes;
            paint_reg <= set_in.paint;
        end
        if (|mask_reg)
        begin
            out_box_reg   <= sel_box;
            out_paint_reg <= paint_reg;
        end
    end

    assign box_valid = valid_reg;
    assign final_box = final_reg;
    assign box_x_lo  = out_box_reg.x_lo;
    assign box_x_hi  = out_box_reg.x_hi;
    assign box_y_lo  = out_box_reg.y_lo;
    assign box_y_hi  = out_box_reg.y_hi;
    assign box_paint = out_paint_reg;

endmodule

>>> rtl/clipped_rectangle_span_gen.sv
// ============================================================================
// clipped_rectangle_span_gen - clipped rectangle fill and outline boxes
// Clips each rectangle request against the clip window and gives the boxes
// to paint: at most a single box in fill mode, and in outline mode any of the
// edges top, bottom, left and right.
//
//   channel   handshake                     payload
//   request   start in, busy out            start_x start_y len_x len_y solid paint
//   box       box_valid out (no stall)      box_x_lo box_x_hi box_y_lo box_y_hi
//                                           box_paint final_box
//   config    APB psel penable pwrite       paddr pwdata prdata pready
//
// A request is registered, clipped in one pass and its boxes are loaded into
// a four-entry box buffer; each box then passes through a result register.
// The buffer sends one box a cycle, up to four per request, and takes the
// next request's boxes as its last box goes out. busy is high while
// the request register waits for the buffer. Reset is asynchronous and
// clears all control state; the clip window resets to 0, 0, 800, 480.
// ============================================================================
module clipped_rectangle_span_gen (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [csg_pkg::AddrW-1:0]          paddr,
    input  logic [csg_pkg::DataW-1:0]          pwdata,
    output logic [csg_pkg::DataW-1:0]          prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [csg_pkg::CoordW-1:0]  start_x,
    input  logic signed [csg_pkg::CoordW-1:0]  start_y,
    input  logic signed [csg_pkg::CoordW-1:0]  len_x,
    input  logic signed [csg_pkg::CoordW-1:0]  len_y,
    input  logic                               solid,
    input  logic [csg_pkg::PaintW-1:0]         paint,
    output logic                               box_valid,
    output logic signed [csg_pkg::CoordW-1:0]  box_x_lo,
    output logic signed [csg_pkg::CoordW-1:0]  box_x_hi,
    output logic signed [csg_pkg::CoordW-1:0]  box_y_lo,
    output logic signed [csg_pkg::CoordW-1:0]  box_y_hi,
    output logic [csg_pkg::PaintW-1:0]         box_paint,
    output logic                               final_box
);

    csg_pkg::clip_t    clip;
    csg_pkg::box_set_t box_set;
    logic              set_valid;
    logic              take_ok;

    csg_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .clip    (clip)
    );

    csg_clip u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .start_x   (start_x),
        .start_y   (start_y),
        .len_x     (len_x),
        .len_y     (len_y),
        .solid     (solid),
        .paint     (paint),
        .clip      (clip),
        .take_ok   (take_ok),
        .set_valid (set_valid),
        .set_out   (box_set)
    );

    csg_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_valid (set_valid),
        .set_in    (box_set),
        .take_ok   (take_ok),
        .box_valid (box_valid),
        .box_x_lo  (box_x_lo),
        .box_x_hi  (box_x_hi),
        .box_y_lo  (box_y_lo),
        .box_y_hi  (box_y_hi),
        .box_paint (box_paint),
        .final_box (final_box)
    );

    a_final_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        final_box |-> box_valid)
        else $error("final_box without box_valid");

    a_boxes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !final_box |=> box_valid)
        else $error("gap inside the boxes of one item");

    a_paint_held: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !final_box |=> $stable(box_paint))
        else $error("colour changed inside the boxes of one item");

    a_busy_drains: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !take_ok && !set_valid)
        else $error("busy while the box buffer can take the item");

endmodule

>>> tb/clipped_rectangle_span_gen_tb.sv
// ----------------------------------------------------------------------------
// clipped_rectangle_span_gen_tb - self-checking bench for the box generator
// Sends rectangle requests through the start/busy port. A table of directed
// items comes first. Random items follow under several clip windows, which
// are set and read back over the register port. The expected boxes come from
// a local clipping predictor or, for some directed rows, the table; every
// box strobed out is compared field by field with the oldest awaited box.
// ----------------------------------------------------------------------------
module clipped_rectangle_span_gen_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csg_pkg::*;

    localparam logic FILL    = 1'b1;
    localparam logic OUTLINE = 1'b0;
    localparam int   SETTLE  = 10;

    typedef struct {
        logic signed [CoordW-1:0] sx;
        logic signed [CoordW-1:0] sy;
        logic signed [CoordW-1:0] lx;
        logic signed [CoordW-1:0] ly;
        logic                     fill;
        logic [PaintW-1:0]        colour;
    } rect_t;

    typedef enum int {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_e;

    typedef struct {
        rect_t    rq;
        row_chk_e chk;
        int       xl;
        int       xh;
        int       yl;
        int       yh;
    } row_t;

    typedef struct {
        box_t              b;
        logic [PaintW-1:0] colour;
        logic              last;
    } exp_box_t;

    logic                     clk;
    logic                     rst_n   = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [AddrW-1:0]         paddr   = '0;
    logic [DataW-1:0]         pwdata  = '0;
    logic [DataW-1:0]         prdata;
    logic                     pready;
    logic                     start   = 1'b0;
    logic                     busy;
    logic signed [CoordW-1:0] start_x = '0;
    logic signed [CoordW-1:0] start_y = '0;
    logic signed [CoordW-1:0] len_x   = '0;
    logic signed [CoordW-1:0] len_y   = '0;
    logic                     solid   = 1'b0;
    logic [PaintW-1:0]        paint   = '0;
    logic                     box_valid;
    logic signed [CoordW-1:0] box_x_lo;
    logic signed [CoordW-1:0] box_x_hi;
    logic signed [CoordW-1:0] box_y_lo;
    logic signed [CoordW-1:0] box_y_hi;
    logic [PaintW-1:0]        box_paint;
    logic                     final_box;

    clip_t    win = '{ResetClipLeft, ResetClipTop, ResetClipRight, ResetClipBottom};
    exp_box_t pending_boxes[$];
    int       n_fail     = 0;
    int       n_directed = 0;
    int       n_random   = 0;
    int       n_boxes    = 0;
    int       n_windows  = 0;

    row_t script[19] = '{
        '{'{16'sd10, 16'sd20, 16'sd30, 16'sd40, FILL, 24'hABCDEF}, CHK_ONE, 10, 40, 20, 60},
        '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, FILL, 24'hFFFFFF}, CHK_NONE, 0, 0, 0, 0},
        '{'{-16'sd100, -16'sd100, 16'sh7FFF, 16'sh7FFF, FILL, 24'h000000}, CHK_ONE,
          0, 800, 0, 480},
        '{'{16'sh7FFF, 16'sd0, 16'sd1, 16'sd1, FILL, 24'h123456}, CHK_NONE, 0, 0, 0, 0},
        '{'{16'sd800, 16'sd10, 16'sd5, 16'sd5, OUTLINE, 24'h654321}, CHK_NONE, 0, 0, 0, 0},
        '{'{16'sd10, 16'sd480, 16'sd5, 16'sd5, FILL, 24'h0F0F0F}, CHK_NONE, 0, 0, 0, 0},
        '{'{-16'sd10, 16'sd10, 16'sd10, 16'sd10, FILL, 24'hF0F0F0}, CHK_NONE, 0, 0, 0, 0},
        '{'{16'sd10, 16'sd10, 16'sd0, 16'sd0, FILL, 24'h000001}, CHK_NONE, 0, 0, 0, 0},
        '{'{16'sd400, 16'sd200, 16'sh8000, 16'sd10, FILL, 24'h800000}, CHK_NONE, 0, 0, 0, 0},
        '{'{16'sh7FFF, 16'sd5, 16'sd1, 16'sd1, OUTLINE, 24'h00FF00}, CHK_NONE, 0, 0, 0, 0},
        '{'{16'sd799, 16'sd479, 16'sd1, 16'sd1, FILL, 24'h800001}, CHK_ONE, 799, 800, 479, 480},
        '{'{16'sd100, 16'sd100, 16'sd50, 16'sd20, OUTLINE, 24'h112233}, CHK_MODEL, 0, 0, 0, 0},
        '{'{16'sd5, 16'sd5, 16'sd1, 16'sd1, OUTLINE, 24'h445566}, CHK_MODEL, 0, 0, 0, 0},
        '{'{16'sd100, 16'sd100, -16'sd20, -16'sd20, OUTLINE, 24'h778899}, CHK_MODEL, 0, 0, 0, 0},
        '{'{-16'sd5, -16'sd5, 16'sd20, 16'sd20, OUTLINE, 24'hAABBCC}, CHK_MODEL, 0, 0, 0, 0},
        '{'{16'sd790, 16'sd470, 16'sd20, 16'sd20, OUTLINE, 24'hDDEEFF}, CHK_MODEL, 0, 0, 0, 0},
        '{'{16'sd0, 16'sd0, 16'sd800, 16'sd480, OUTLINE, 24'h5A5A5A}, CHK_MODEL, 0, 0, 0, 0},
        '{'{16'sd1, 16'sd1, 16'sh8000, 16'sh8000, OUTLINE, 24'hA5A5A5}, CHK_MODEL, 0, 0, 0, 0},
        '{'{16'sd200, 16'sd300, 16'sd1, 16'sh7FFF, OUTLINE, 24'h7FFFFF}, CHK_MODEL, 0, 0, 0, 0}
    };

    clip_t windows[5] = '{
        '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF},
        '{16'sd100, 16'sd50, 16'sd164, 16'sd90},
        '{-16'sd300, -16'sd200, -16'sd16, -16'sd8},
        '{16'sd500, 16'sd400, 16'sd100, 16'sd50},
        '{16'sd20, 16'sd20, 16'sd20, 16'sd20}
    };

    clipped_rectangle_span_gen dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void add_box(int xl, int xh, int yl, int yh, logic [PaintW-1:0] c);
        exp_box_t e;
        if (xl < xh && yl < yh)
        begin
            e.b.x_lo = xl[CoordW-1:0];
            e.b.x_hi = xh[CoordW-1:0];
            e.b.y_lo = yl[CoordW-1:0];
            e.b.y_hi = yh[CoordW-1:0];
            e.colour = c;
            e.last   = 1'b0;
            pending_boxes.push_back(e);
        end
    endfunction

    function automatic void clip_rectangle(rect_t r);
        int       xs, ys, xe, ye, cl, ct, cr, cb, x0, x1, y0, y1, n0;
        exp_box_t tail;
        xs = int'(r.sx);
        ys = int'(r.sy);
        xe = xs + int'(r.lx);
        ye = ys + int'(r.ly);
        cl = int'(win.left);
        ct = int'(win.top);
        cr = int'(win.right);
        cb = int'(win.bottom);
        n0 = pending_boxes.size();
        if (xs >= cr || ys >= cb || xe < cl || ye < ct)
            return;
        x0 = (xs > cl) ? xs : cl;
        x1 = (xe < cr) ? xe : cr;
        y0 = (ys > ct) ? ys : ct;
        y1 = (ye < cb) ? ye : cb;
        if (r.fill)
            add_box(x0, x1, y0, y1, r.colour);
        else
        begin
            if (ys >= ct)
                add_box(x0, x1, ys, ys + 1, r.colour);
            if (ye <= cb && ye - 1 >= ct)
                add_box(x0, x1, ye - 1, ye, r.colour);
            if (xs >= cl)
                add_box(xs, xs + 1, y0, y1, r.colour);
            if (xe <= cr && xe - 1 >= cl)
                add_box(xe - 1, xe, y0, y1, r.colour);
        end
        if (pending_boxes.size() > n0)
        begin
            tail = pending_boxes.pop_back();
            tail.last = 1'b1;
            pending_boxes.push_back(tail);
        end
    endfunction

    function automatic void check_field(string f, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            n_fail++;
            $display("%0t ns: box %s mismatch, expected %0d, actual %0d", $time, f, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        exp_box_t e;
        if (rst_n && box_valid)
        begin
            if (pending_boxes.size() == 0)
            begin
                n_fail++;
                $display("%0t ns: box with none awaited, expected nothing, actual %0d %0d %0d %0d",
                         $time, box_x_lo, box_x_hi, box_y_lo, box_y_hi);
            end
            else
            begin
                e = pending_boxes.pop_front();
                n_boxes++;
                check_field("x_lo", e.b.x_lo, box_x_lo);
                check_field("x_hi", e.b.x_hi, box_x_hi);
                check_field("y_lo", e.b.y_lo, box_y_lo);
                check_field("y_hi", e.b.y_hi, box_y_hi);
                check_field("paint", {8'd0, e.colour}, {8'd0, box_paint});
                check_field("final", {31'd0, e.last}, {31'd0, final_box});
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, logic signed [CoordW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DataW-CoordW){val[CoordW-1]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CLIP_LEFT:   win.left   = val;
            REG_CLIP_TOP:    win.top    = val;
            REG_CLIP_RIGHT:  win.right  = val;
            REG_CLIP_BOTTOM: win.bottom = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apb_read(logic [1:0] idx, logic signed [CoordW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[CoordW-1:0] !== want)
        begin
            n_fail++;
            $display("%0t ns: register %0d read mismatch, expected %0d, actual %0d",
                     $time, idx, want, $signed(prdata[CoordW-1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_back_window();
        apb_read(REG_CLIP_LEFT, win.left);
        apb_read(REG_CLIP_TOP, win.top);
        apb_read(REG_CLIP_RIGHT, win.right);
        apb_read(REG_CLIP_BOTTOM, win.bottom);
    endtask

    task automatic issue_rect(rect_t r, row_chk_e chk, box_t typed);
        exp_box_t e;
        start   <= 1'b1;
        start_x <= r.sx;
        start_y <= r.sy;
        len_x   <= r.lx;
        len_y   <= r.ly;
        solid   <= r.fill;
        paint   <= r.colour;
        do @(posedge clk); while (busy);
        case (chk)
            CHK_MODEL: clip_rectangle(r);
            CHK_ONE:
            begin
                e.b      = typed;
                e.colour = r.colour;
                e.last   = 1'b1;
                pending_boxes.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic pause_sender(int pct);
        int n;
        n = 0;
        while (n < 20 && $urandom_range(99) < pct)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_boxes();
        int spins;
        start <= 1'b0;
        spins = 0;
        while (pending_boxes.size() != 0 && spins < 400)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_boxes.size() != 0)
        begin
            n_fail++;
            $display("%0t ns: %0d boxes never arrived, expected 0 left, actual %0d left",
                     $time, pending_boxes.size(), pending_boxes.size());
            pending_boxes.delete();
        end
    endtask

    function automatic logic [CoordW-1:0] pick_coord(int lo, int hi);
        int a, b, v;
        a = ((lo < hi) ? lo : hi) - 40;
        b = ((lo < hi) ? hi : lo) + 40;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = a + int'($urandom_range(b - a));
            6:                v = int'($urandom);
            7:
            begin
                case ($urandom_range(3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    default: v = 0;
                endcase
            end
            8:       v = lo - int'($urandom_range(1));
            default: v = hi - int'($urandom_range(1));
        endcase
        return v[CoordW-1:0];
    endfunction

    function automatic logic [CoordW-1:0] pick_len(int span);
        int v;
        case ($urandom_range(7))
            0, 1, 2, 3: v = int'($urandom_range(70)) - 10;
            4:          v = span - int'($urandom_range(2));
            5:          v = -int'($urandom_range(60));
            6:          v = int'($urandom);
            default:
            begin
                case ($urandom_range(3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 1;
                    default: v = 0;
                endcase
            end
        endcase
        return v[CoordW-1:0];
    endfunction

    initial
    begin
        rect_t r;
        int    pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_back_window();

        foreach (script[i])
        begin
            pause_sender(34);
            issue_rect(script[i].rq, script[i].chk,
                       '{script[i].xl[CoordW-1:0], script[i].xh[CoordW-1:0],
                         script[i].yl[CoordW-1:0], script[i].yh[CoordW-1:0]});
            n_directed++;
        end
        drain_boxes();

        foreach (windows[w])
        begin
            apb_write(REG_CLIP_LEFT, windows[w].left);
            apb_write(REG_CLIP_TOP, windows[w].top);
            apb_write(REG_CLIP_RIGHT, windows[w].right);
            apb_write(REG_CLIP_BOTTOM, windows[w].bottom);
            read_back_window();
            n_windows++;
            for (int k = 0; k < 30; k++)
            begin
                pct = (n_random < 50) ? 34 : (n_random < 100) ? 78 : 0;
                r.sx     = pick_coord(int'(win.left), int'(win.right));
                r.sy     = pick_coord(int'(win.top), int'(win.bottom));
                r.lx     = pick_len(int'(win.right) - int'(win.left));
                r.ly     = pick_len(int'(win.bottom) - int'(win.top));
                r.fill   = 1'($urandom_range(1));
                r.colour = 24'($urandom);
                pause_sender(pct);
                issue_rect(r, CHK_MODEL, '0);
                n_random++;
                if ($urandom_range(29) == 0)
                    drain_boxes();
            end
            drain_boxes();
        end

        $display("Sent %0d directed and %0d random requests under %0d clip windows.",
                 n_directed, n_random, n_windows + 1);
        $display("Checked %0d boxes in fill and outline modes, with register read-back.",
                 n_boxes);
        if (n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/csg_pkg.sv
rtl/csg_cfg_regs.sv
rtl/csg_clip.sv
rtl/csg_emit.sv
rtl/clipped_rectangle_span_gen.sv
tb/clipped_rectangle_span_gen_tb.sv
